@@ rtl/serial_command_line_decoder_top_macros.svh @@
// Assertion macros for the command line decoder.
`ifndef SERIAL_COMMAND_LINE_DECODER_TOP_MACROS_SVH
`define SERIAL_COMMAND_LINE_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check: antecedent implies consequent in the same cycle.
`define SCLD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scld check failed");
// Check that the antecedent implies the consequent in the next cycle.
`define SCLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scld check failed");
`else
`define SCLD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCLD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/scld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scld_pkg;

  localparam int LINE_CAPACITY_DEF = 80;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TICK  = 8'h60;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    EV_SPEED    = 4'd0,
    EV_BIAS     = 4'd1,
    EV_STOP     = 4'd2,
    EV_INIT     = 4'd3,
    EV_UPDATE   = 4'd4,
    EV_REPORT   = 4'd5,
    EV_UNKNOWN  = 4'd6,
    EV_OVERFLOW = 4'd7,
    EV_CLEARED  = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic scan_step;
    logic scan_proc;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic is_eol;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/scld_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface scld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/scld_event_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface scld_event_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  event_code;
  logic signed [31:0] argument;
  logic        [7:0]  command_letter;

  modport source (output valid, output event_code, output argument,
                  output command_letter, input ready);
  modport sink (input valid, input event_code, input argument,
                input command_letter, output ready);
endinterface
`default_nettype wire

@@ rtl/serial_command_line_decoder_top.sv @@
// Channel  Dir  Payload                                   Handshake
// rx       in   rx_byte[7:0]                              valid/ready
// ev       out  event_code[3:0] argument[31:0] letter[7:0] valid/ready
//
// A byte that only edits the line is taken without starting a scan.
// CR or LF walks the stored line one character a cycle through the line
// memory read port until the line ends or holds a non-numeric character.
// Synchronous reset empties the line; memory contents are not cleared.
// rx is held off during a scan and while the output register holds an untaken word.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_command_line_decoder_top_macros.svh"
module serial_command_line_decoder_top #(
  parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  scld_byte_if.sink   rx,
  scld_event_if.source ev
);
  import scld_pkg::*;

  ctl_t ctl;
  sts_t sts;

  scld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  scld_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx.rx_byte),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (ev.valid),
    .out_ready      (ev.ready),
    .event_code     (ev.event_code),
    .argument       (ev.argument),
    .command_letter (ev.command_letter)
  );

  `SCLD_ASSERT_IMP(a_ready_needs_room, clk, rst, rx.ready, (!ev.valid || ev.ready))
  `SCLD_ASSERT_IMP(a_no_take_in_scan, clk, rst, ctl.scan_step, !rx.ready)
  `SCLD_ASSERT_NEXT(a_eol_starts_scan, clk, rst, (ctl.take && sts.is_eol), ctl.scan_step)
  `SCLD_ASSERT_IMP(a_emit_has_room, clk, rst, ctl.emit, sts.out_free)

endmodule
`default_nettype wire

@@ rtl/scld_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/scld_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scld_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_ready,
  input  wire scld_pkg::sts_t sts,
  output scld_pkg::ctl_t     ctl
);
  import scld_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rx_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        rx_ready = sts.out_free;
        ctl.take = rx_valid && sts.out_free;
        if (ctl.take && sts.is_eol) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        ctl.scan_step = 1'b1;
        state_next    = ST_WALK;
      end
      ST_WALK: begin
        ctl.scan_step = 1'b1;
        ctl.scan_proc = 1'b1;
        if (sts.scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/scld_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scld_dp #(
  parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         rx_byte,
  input  wire scld_pkg::ctl_t     ctl,
  output scld_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic        [3:0]       event_code,
  output logic signed [31:0]      argument,
  output logic        [7:0]       command_letter
);
  import scld_pkg::*;

  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);

  logic [LW-1:0] length;
  logic [LW-1:0] eff_len;
  logic [7:0]    first_char;
  logic          first_zero;

  logic [LW-1:0] scan_len;
  logic [LW-1:0] rptr;
  logic [LW-1:0] dpos;
  logic [7:0]    letter;
  logic          negative;
  logic          bad;
  logic          has_rest;
  logic [31:0]   mag;
  logic [35:0]   prod;
  logic [31:0]   mag_next;

  logic [7:0]    rdata;
  logic          we;

  logic is_bs, is_tick, is_tab, is_eol, is_full;
  logic in_line, is_minus, is_digit;
  logic is_int;

  logic          res_ok;
  event_t        res_code;
  logic [31:0]   res_arg;
  logic [31:0]   value;
  logic          load;
  event_t        load_code;
  logic [31:0]   load_arg;
  logic [7:0]    load_letter;

  event_t        ev_reg;

  assign eff_len = (length != '0 && first_zero) ? '0 : length;
  assign is_bs   = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  assign is_tick = (rx_byte == CH_TICK);
  assign is_tab  = (rx_byte == CH_TAB);
  assign is_eol  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_full = (eff_len == LW'(LINE_CAPACITY));

  assign we = ctl.take && !is_bs && !is_tick && !is_tab && !is_eol && !is_full;

  scld_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (eff_len[AW-1:0]),
    .wdata (rx_byte),
    .raddr (rptr[AW-1:0]),
    .rdata (rdata)
  );

  assign in_line  = (dpos < scan_len) && (rdata != CH_NUL);
  assign is_minus = (dpos == LW'(1)) && (rdata == CH_MINUS);
  assign is_digit = (rdata >= CH_ZERO) && (rdata <= CH_NINE);
  assign prod     = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + 36'(rdata[3:0]);
  assign mag_next = (prod > 36'h0_8000_0000) ? 32'h8000_0001 : prod[31:0];

  assign sts.is_eol   = is_eol;
  assign sts.scan_end = !in_line || (!is_minus && !is_digit);
  assign sts.out_free = !out_valid || out_ready;

  assign is_int = has_rest && !bad;

  always_comb begin
    if (negative) begin
      value = (mag >= 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag);
    end else begin
      value = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    end
  end

  always_comb begin
    res_ok   = 1'b1;
    res_code = EV_UNKNOWN;
    res_arg  = '0;
    unique case (letter)
      CH_V: begin
        res_ok   = is_int;
        res_code = EV_SPEED;
        res_arg  = value;
      end
      CH_B: begin
        res_ok   = is_int;
        res_code = EV_BIAS;
        res_arg  = value;
      end
      CH_N: begin
        res_ok   = !has_rest;
        res_code = EV_STOP;
      end
      CH_I: begin
        res_ok   = !has_rest;
        res_code = EV_INIT;
      end
      CH_U: begin
        res_ok   = !has_rest;
        res_code = EV_UPDATE;
      end
      CH_P: begin
        res_ok   = !has_rest;
        res_code = EV_REPORT;
      end
      default: begin
        res_ok   = 1'b1;
        res_code = EV_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    load        = 1'b0;
    load_code   = EV_CLEARED;
    load_arg    = '0;
    load_letter = '0;
    priority if (ctl.emit) begin
      load        = res_ok;
      load_code   = res_code;
      load_arg    = res_arg;
      load_letter = letter;
    end else if (ctl.take && is_tick) begin
      load      = 1'b1;
      load_code = EV_CLEARED;
    end else if (ctl.take && !is_bs && !is_tab && !is_eol && is_full) begin
      load      = 1'b1;
      load_code = EV_OVERFLOW;
    end else begin
      load = 1'b0;
    end
  end

  // Line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      length     <= '0;
      first_zero <= 1'b0;
    end else if (ctl.take) begin
      priority if (is_bs) begin
        length <= (eff_len != '0) ? eff_len - LW'(1) : '0;
      end else if (is_tick || is_eol) begin
        length <= '0;
      end else if (is_tab) begin
        length <= eff_len;
      end else if (is_full) begin
        length <= '0;
      end else begin
        length <= eff_len + LW'(1);
        if (eff_len == '0) begin
          first_zero <= (rx_byte == CH_NUL);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && eff_len == '0) begin
      first_char <= rx_byte;
    end
  end

  // Scan of the stored line
  always_ff @(posedge clk) begin
    if (ctl.take && is_eol) begin
      scan_len <= eff_len;
      letter   <= (eff_len != '0) ? first_char : CH_NUL;
      rptr     <= LW'(1);
      negative <= 1'b0;
      bad      <= 1'b0;
      has_rest <= 1'b0;
      mag      <= '0;
    end else begin
      if (ctl.scan_step) begin
        rptr <= rptr + LW'(1);
        dpos <= rptr;
      end
      if (ctl.scan_proc && in_line) begin
        has_rest <= 1'b1;
        priority if (is_minus) begin
          negative <= 1'b1;
        end else if (is_digit) begin
          mag <= mag_next;
        end else begin
          bad <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_reg         <= load_code;
      argument       <= load_arg;
      command_letter <= load_letter;
    end
  end

  assign event_code = ev_reg;

endmodule
`default_nettype wire
